// ===== hdl/wto_pkg.sv =====
package wto_pkg;

   localparam int TABLE_DEPTH  = 64;
   localparam int SAMPLE_WIDTH = 16;
   localparam int PHASE_BITS   = 32;
   localparam int FRAC_BITS    = 10;

   localparam int ADDR_BITS        = $clog2(TABLE_DEPTH);
   localparam int ACTION_BITS      = 2;
   localparam int INDEX_BITS       = 6;
   localparam int PHASE_FIELD_BITS = 32;
   localparam int STEP_BITS        = 32;

   // (b - a) is one bit wider than a sample, the fraction gets a sign bit
   localparam int PROD_BITS  = SAMPLE_WIDTH + FRAC_BITS + 2;
   localparam int ROUND_HALF = 1 << (FRAC_BITS - 1);

   typedef enum logic [ACTION_BITS-1:0] {
      ACT_LOAD   = 2'd0,
      ACT_PHASE  = 2'd1,
      ACT_SAMPLE = 2'd2
   } action_type;

endpackage

// ===== hdl/wto_if.sv =====
interface wto_req_if import wto_pkg::*; ();
   logic                               valid;
   logic                               ready;
   logic        [ACTION_BITS-1:0]      action;
   logic        [INDEX_BITS-1:0]       table_index;
   logic signed [SAMPLE_WIDTH-1:0]     table_value;
   logic        [PHASE_FIELD_BITS-1:0] phase_value;
   logic signed [STEP_BITS-1:0]        phase_step;

   modport source (output valid, action, table_index, table_value, phase_value, phase_step,
                   input ready);
   modport sink   (input valid, action, table_index, table_value, phase_value, phase_step,
                   output ready);
endinterface

interface wto_rsp_if import wto_pkg::*; ();
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sample;

   modport source (output valid, sample, input ready);
   modport sink   (input valid, sample, output ready);
endinterface

// ===== hdl/wavetable_oscillator_interp.sv =====
// A sample word passes the stage 1 read, stage 2 product and output registers.
// Throughput: one request word per cycle while rsp_bus is ready; table reads come
// from a dual-read-port table memory, the phase update is a single add per cycle.
// Load and set-phase words produce no response.
// Reset clears the phase accumulator and all pipeline valids; the wave table is
// undefined until loaded and needs no clearing pass.
module wavetable_oscillator_interp import wto_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   wto_req_if.sink   req_bus,
   wto_rsp_if.source rsp_bus
);

   logic signed [SAMPLE_WIDTH-1:0] wave_mem [TABLE_DEPTH];

   logic [PHASE_BITS-1:0] phase_ff, phase_in;
   logic                  req_accept, load_acc, sample_acc;

   logic                           s1_valid_ff;
   logic signed [SAMPLE_WIDTH-1:0] rd_lo_ff, rd_hi_ff;
   logic        [FRAC_BITS-1:0]    frac_ff;

   logic                           s2_valid_ff;
   logic signed [PROD_BITS-1:0]    prod_ff, prod_in;
   logic signed [SAMPLE_WIDTH-1:0] base_ff;

   logic                           rsp_valid_ff;
   logic signed [SAMPLE_WIDTH-1:0] sample_ff, sample_in;

   logic out_free, s2_free, s1_free;

   logic [ADDR_BITS-1:0]        lo_addr, hi_addr;
   logic [FRAC_BITS-1:0]        frac_in;
   logic signed [SAMPLE_WIDTH:0] diff;
   logic signed [FRAC_BITS:0]    frac_ext;
   logic signed [PROD_BITS-1:0]  rounded;

   // each stage moves when the one after it is empty or moving
   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign s2_free  = !s2_valid_ff || out_free;
   assign s1_free  = !s1_valid_ff || s2_free;

   assign req_bus.ready = s1_free;
   assign req_accept    = req_bus.valid && s1_free;

   always_comb begin
      load_acc   = 1'b0;
      sample_acc = 1'b0;
      phase_in   = phase_ff;
      if (req_accept) begin
         unique case (req_bus.action)
            ACT_LOAD: begin
               load_acc = 1'b1;
            end
            ACT_PHASE: begin
               phase_in = PHASE_BITS'(req_bus.phase_value);
            end
            ACT_SAMPLE: begin
               sample_acc = 1'b1;
               phase_in   = phase_ff + PHASE_BITS'(req_bus.phase_step);
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
      end else begin
         phase_ff <= phase_in;
      end
   end

   // top bits pick the entry, the bits just below give the blend fraction
   assign lo_addr = phase_ff[PHASE_BITS-1 -: ADDR_BITS];
   assign hi_addr = lo_addr + ADDR_BITS'(1);
   assign frac_in = phase_ff[PHASE_BITS-ADDR_BITS-1 -: FRAC_BITS];

   always_ff @(posedge clock) begin
      if (load_acc) begin
         wave_mem[ADDR_BITS'(req_bus.table_index)] <= req_bus.table_value;
      end
   end

   // hold the read data while stage 1 is stalled
   always_ff @(posedge clock) begin
      if (s1_free) begin
         rd_lo_ff <= wave_mem[lo_addr];
         rd_hi_ff <= wave_mem[hi_addr];
         frac_ff  <= frac_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_free) begin
         s1_valid_ff <= sample_acc;
      end
   end

   assign diff     = {rd_hi_ff[SAMPLE_WIDTH-1], rd_hi_ff} - {rd_lo_ff[SAMPLE_WIDTH-1], rd_lo_ff};
   assign frac_ext = signed'({1'b0, frac_ff});
   assign prod_in  = PROD_BITS'(diff) * PROD_BITS'(frac_ext);

   always_ff @(posedge clock) begin
      if (s2_free) begin
         prod_ff <= prod_in;
         base_ff <= rd_lo_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_free) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   // round half up, then add to the lower entry; the sum stays between both entries
   assign rounded   = (prod_ff + PROD_BITS'(ROUND_HALF)) >>> FRAC_BITS;
   assign sample_in = base_ff + rounded[SAMPLE_WIDTH-1:0];

   always_ff @(posedge clock) begin
      if (out_free) begin
         sample_ff <= sample_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   assign rsp_bus.valid  = rsp_valid_ff;
   assign rsp_bus.sample = sample_ff;

   a_sample_enters_pipe: assert property (@(posedge clock) disable iff (reset)
      sample_acc |=> s1_valid_ff)
      else $error("accepted sample word did not enter stage 1");

   a_phase_steps: assert property (@(posedge clock) disable iff (reset)
      sample_acc |=> phase_ff == $past(phase_ff + PHASE_BITS'(req_bus.phase_step)))
      else $error("phase did not advance by the step after a sample word");

   a_stage2_holds: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && !out_free |=> s2_valid_ff && $stable(prod_ff) && $stable(base_ff))
      else $error("stage 2 lost its word while the output was stalled");

   a_no_accept_when_full: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s2_valid_ff && rsp_valid_ff && !rsp_bus.ready |-> !req_bus.ready)
      else $error("request taken while the whole pipeline was stalled");

endmodule

// ===== verif/wto_sample_checker.sv =====
`timescale 1ns / 100ps

module wto_sample_checker import wto_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   wto_req_if        req_bus,
   wto_rsp_if        rsp_bus,
   output int        fail_count,
   output int        samples_due
);

   localparam int PRINT_LIMIT = 40;

   logic        [PHASE_BITS-1:0]   phase;
   logic signed [SAMPLE_WIDTH-1:0] wave [TABLE_DEPTH];
   logic signed [SAMPLE_WIDTH-1:0] expected_samples [$];
   logic signed [SAMPLE_WIDTH-1:0] expected;

   initial begin
      fail_count  = 0;
      samples_due = 0;
   end

   task automatic report_mismatch(input string msg);
      if (fail_count < PRINT_LIMIT) begin
         $display("[%0t] rsp_bus: %s", $time, msg);
      end
      fail_count++;
   endtask

   // Linear blend between the entry at the phase and the one above it (wraps at the top).
   function automatic logic signed [SAMPLE_WIDTH-1:0] interpolate(
      input logic [PHASE_BITS-1:0] ph);
      logic [ADDR_BITS-1:0] lo;
      logic [ADDR_BITS-1:0] hi;
      longint               frac;
      longint               a;
      longint               b;
      longint               blend;
      lo    = ph[PHASE_BITS-1 -: ADDR_BITS];
      hi    = lo + 1'b1;
      frac  = longint'(ph[PHASE_BITS-ADDR_BITS-1 -: FRAC_BITS]);
      a     = longint'(wave[lo]);
      b     = longint'(wave[hi]);
      // round half up, floor shift
      blend = ((b - a) * frac + ROUND_HALF) >>> FRAC_BITS;
      return SAMPLE_WIDTH'(a + blend);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         phase = '0;
         expected_samples.delete();
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_samples.size() == 0) begin
               report_mismatch($sformatf("sample %0d with no word expected", rsp_bus.sample));
            end else begin
               expected = expected_samples.pop_front();
               if (rsp_bus.sample !== expected) begin
                  report_mismatch($sformatf("sample %0d, expected %0d",
                                            rsp_bus.sample, expected));
               end
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            case (req_bus.action)
               ACT_LOAD: begin
                  wave[req_bus.table_index] = req_bus.table_value;
               end
               ACT_PHASE: begin
                  phase = req_bus.phase_value;
               end
               ACT_SAMPLE: begin
                  expected_samples.push_back(interpolate(phase));
                  phase = phase + req_bus.phase_step;
               end
               default: ;
            endcase
         end
      end
      samples_due <= expected_samples.size();
   end

endmodule

// ===== verif/wavetable_oscillator_interp_tb.sv =====
`timescale 1ns / 100ps

module wavetable_oscillator_interp_tb;
   import wto_pkg::*;

   localparam logic [ACTION_BITS-1:0] ACT_NONE = 2'd3;

   localparam int RANDOM_WORDS  = 1600;
   localparam int BURST_WORDS   = 60;
   localparam int HOLD_CYCLES   = 300;
   localparam int IDLE_LIMIT    = 2000;
   localparam int DRAIN_CYCLES  = 12;

   logic clock;
   logic reset;
   bit   gaps_on  = 1'b1;
   bit   hold_rsp = 1'b0;
   int   fail_count;
   int   samples_due;
   int   idle_cycles = 0;
   int   pick;

   wto_req_if req_bus ();
   wto_rsp_if rsp_bus ();

   wavetable_oscillator_interp dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   wto_sample_checker sample_check (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .fail_count  (fail_count),
      .samples_due (samples_due)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
   end

   // Stop on a hung channel: count cycles without any accepted word.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end else begin
            rsp_bus.ready <= !(gaps_on && $urandom_range(99) < 33);
         end
      end
   end

   task automatic send_word(input logic [ACTION_BITS-1:0]           act,
                            input logic [INDEX_BITS-1:0]            idx,
                            input logic signed [SAMPLE_WIDTH-1:0]   value,
                            input logic [PHASE_FIELD_BITS-1:0]      ph,
                            input logic signed [STEP_BITS-1:0]      step);
      while (gaps_on && $urandom_range(99) < 33) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.action      <= act;
      req_bus.table_index <= idx;
      req_bus.table_value <= value;
      req_bus.phase_value <= ph;
      req_bus.phase_step  <= step;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   // Unused fields carry random noise.
   task automatic load_entry(input logic [INDEX_BITS-1:0] idx,
                             input logic signed [SAMPLE_WIDTH-1:0] value);
      send_word(ACT_LOAD, idx, value, $urandom, $urandom);
   endtask

   task automatic set_phase(input logic [PHASE_FIELD_BITS-1:0] ph);
      send_word(ACT_PHASE, INDEX_BITS'($urandom), SAMPLE_WIDTH'($urandom), ph, $urandom);
   endtask

   task automatic make_sample(input logic signed [STEP_BITS-1:0] step);
      send_word(ACT_SAMPLE, INDEX_BITS'($urandom), SAMPLE_WIDTH'($urandom), $urandom, step);
   endtask

   // Mostly audio-like steps of either sign, some full-range ones.
   function automatic logic signed [STEP_BITS-1:0] rand_step();
      logic signed [STEP_BITS-1:0] mag;
      mag = $urandom_range(0, 1 << 24);
      if ($urandom_range(3) == 0) begin
         return $urandom;
      end
      return $urandom_range(1) ? mag : -mag;
   endfunction

   initial begin
      req_bus.valid       <= 1'b0;
      req_bus.action      <= ACT_LOAD;
      req_bus.table_index <= '0;
      req_bus.table_value <= '0;
      req_bus.phase_value <= '0;
      req_bus.phase_step  <= '0;
      @(posedge clock);
      while (reset) @(posedge clock);

      // Fill every entry first so no sample reads an unwritten word.
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (i < 8) begin
            load_entry(INDEX_BITS'(i), (i % 2 == 0) ? 16'sh7fff : 16'sh8000);
         end else if (i == TABLE_DEPTH - 1) begin
            load_entry(INDEX_BITS'(i), 16'sh8000);
         end else begin
            load_entry(INDEX_BITS'(i), SAMPLE_WIDTH'($urandom));
         end
      end

      // Phase at zero, extreme steps, wrap in both directions.
      set_phase(32'h0000_0000);
      make_sample(32'sh0000_0000);
      make_sample(32'sh7fff_ffff);
      make_sample(32'sh8000_0000);
      make_sample(32'sh0000_0001);
      make_sample(-32'sh0000_0001);
      make_sample(32'sh0000_0000);
      // Half-way fraction across full-scale steps in the table.
      set_phase(32'h0200_0000);
      make_sample(32'sh0400_0000);
      make_sample(32'sh0000_0400);
      send_word(ACT_NONE, 6'h3f, 16'sh7fff, 32'hffff_ffff, 32'sh7fff_ffff);
      // Read a word right after it is loaded.
      load_entry(6'd2, 16'sh0000);
      set_phase(32'h0800_0000);
      make_sample(32'sh0000_0000);
      // Upper neighbor wraps from the last entry to entry 0.
      load_entry(6'd63, 16'sh7fff);
      set_phase(32'hffc0_0000);
      make_sample(32'sh0000_0000);
      set_phase(32'hffff_ffff);
      make_sample(32'sh0000_0000);

      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n == 400) begin
            // Hold the response side off and keep pushing sample words.
            hold_rsp = 1'b1;
            gaps_on  = 1'b0;
            repeat (BURST_WORDS) make_sample(rand_step());
            gaps_on  = 1'b1;
         end
         if (n == 900) gaps_on = 1'b0;
         if (n == 1200) gaps_on = 1'b1;
         pick = $urandom_range(99);
         if (pick < 10) begin
            load_entry(INDEX_BITS'($urandom), SAMPLE_WIDTH'($urandom));
         end else if (pick < 18) begin
            set_phase($urandom);
         end else if (pick < 20) begin
            send_word(ACT_NONE, INDEX_BITS'($urandom), SAMPLE_WIDTH'($urandom),
                      $urandom, $urandom);
         end else begin
            make_sample(rand_step());
         end
      end
      req_bus.valid <= 1'b0;

      while (samples_due != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && samples_due == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
